@@ rtl/sitrd_pkg.sv @@
// Shared types, constants and the reciprocal table of the radix digit converter.
// No dependencies; every other file of the block imports this package.
`default_nettype none

package sitrd_pkg;

  // Field and storage sizes
  localparam int unsigned VALUE_W      = 32;
  localparam int unsigned CHAR_W       = 8;
  localparam int unsigned CFG_DATA_W   = 64;
  localparam int unsigned CFG_IDX_W    = 2;
  localparam int unsigned LEN_W        = 5;
  localparam int unsigned MAX_RADIX_DEF = 16;
  localparam int unsigned DIGIT_DEPTH  = 32;
  localparam int unsigned PTR_W        = $clog2(DIGIT_DEPTH);
  localparam int unsigned CNT_W        = PTR_W + 1;
  localparam int unsigned REM_W        = LEN_W + 1;
  localparam int unsigned BYTES_PER_WORD = CFG_DATA_W / CHAR_W;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_ALPHA_LOW  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_ALPHA_HIGH = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_RADIX_LEN  = 2'd2;

  // Character codes
  localparam logic [CHAR_W-1:0] CHAR_LOW   = 8'd33;
  localparam logic [CHAR_W-1:0] CHAR_HIGH  = 8'd126;
  localparam logic [CHAR_W-1:0] PLUS_CHAR  = 8'h2B;
  localparam logic [CHAR_W-1:0] MINUS_CHAR = 8'h2D;

  localparam logic [LEN_W-1:0] MIN_RADIX = 5'd2;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CHECK,
    ST_MUL,
    ST_FIX,
    ST_SIGN,
    ST_EMIT
  } state_e;

  // Controller to datapath
  typedef struct packed {
    logic load;        // capture the magnitude of a new value
    logic mul;         // register magnitude times reciprocal
    logic fix;         // correct quotient, push digit
    logic emit_sign;   // load a minus sign into the output register
    logic emit_digit;  // pop a digit into the output register
  } cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic alpha_ok;
    logic neg;
    logic quo_zero;
    logic last_digit;
    logic out_free;
  } status_t;

  // floor(2^32 / d) for the radixes in use; the estimate it gives is
  // the true quotient or one below it for any magnitude under 2^32.
  function automatic logic [VALUE_W-1:0] recip_f(input logic [LEN_W-1:0] d);
    logic [VALUE_W-1:0] r;
    begin
      unique case (d)
        5'd2:    r = 32'h8000_0000;
        5'd3:    r = 32'h5555_5555;
        5'd4:    r = 32'h4000_0000;
        5'd5:    r = 32'h3333_3333;
        5'd6:    r = 32'h2AAA_AAAA;
        5'd7:    r = 32'h2492_4924;
        5'd8:    r = 32'h2000_0000;
        5'd9:    r = 32'h1C71_C71C;
        5'd10:   r = 32'h1999_9999;
        5'd11:   r = 32'h1745_D174;
        5'd12:   r = 32'h1555_5555;
        5'd13:   r = 32'h13B1_3B13;
        5'd14:   r = 32'h1249_2492;
        5'd15:   r = 32'h1111_1111;
        5'd16:   r = 32'h1000_0000;
        default: r = '0;
      endcase
      return r;
    end
  endfunction

endpackage

`default_nettype wire

@@ rtl/sitrd_if.sv @@
// Valid/ready channel interfaces of the radix digit converter.
// Depends on sitrd_pkg for the field widths.
`default_nettype none

interface sitrd_in_if;
  import sitrd_pkg::*;
  logic                      valid;
  logic                      ready;
  logic signed [VALUE_W-1:0] value;

  modport source (output valid, output value, input ready);
  modport sink   (input valid, input value, output ready);
endinterface

interface sitrd_out_if;
  import sitrd_pkg::*;
  logic              valid;
  logic              ready;
  logic [CHAR_W-1:0] out_char;
  logic              last_char;

  modport source (output valid, output out_char, output last_char, input ready);
  modport sink   (input valid, input out_char, input last_char, output ready);
endinterface

`default_nettype wire

@@ rtl/signed_integer_to_radix_digits.sv @@
// Top level of the signed integer to radix text converter.
// Depends on sitrd_pkg, sitrd_if, sitrd_ctrl and sitrd_dp.
//
// Each accepted 32-bit signed value is written out as characters of a configured
// alphabet: a minus sign for a negative value, then the digits most significant
// first, with last_char set on the final character. The magnitude of the most
// negative value is exact. If the alphabet is unusable (radix below 2 or above
// MAX_RADIX, a character outside 33..126, a plus or minus sign, or a repeated
// character) the value produces no characters. The value is taken in ST_IDLE and
// the alphabet is checked in ST_CHECK; each digit then passes through the shared
// reciprocal multiplier (ST_MUL) and its correction step (ST_FIX); characters
// leave one per cycle while the sink is ready. A new value is taken once the last
// character sits in the output register. Configuration must be written only while
// the block is idle; the block itself does not enforce this.
`default_nettype none

module signed_integer_to_radix_digits
  import sitrd_pkg::*;
#(
  parameter int unsigned MAX_RADIX = MAX_RADIX_DEF
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  cfg_we_i,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  wire logic [CFG_DATA_W-1:0] cfg_wdata_i,
  sitrd_in_if.sink                   in_i,
  sitrd_out_if.source                out_o
);

  cmd_t    cmd;
  status_t status;
  logic    in_ready;

  sitrd_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_i.valid),
    .in_ready_o (in_ready),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  sitrd_dp #(
    .MAX_RADIX (MAX_RADIX)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_wdata_i (cfg_wdata_i),
    .value_i     (in_i.value),
    .cmd_i       (cmd),
    .status_o    (status),
    .out_valid_o (out_o.valid),
    .out_ready_i (out_o.ready),
    .out_char_o  (out_o.out_char),
    .out_last_o  (out_o.last_char)
  );

  assign in_i.ready = in_ready;

endmodule

`default_nettype wire

@@ rtl/sitrd_ctrl.sv @@
// Sequencer of the radix digit converter: check, divide loop, sign and digit emission.
// Depends on sitrd_pkg for the state, command and status types.
`default_nettype none

module sitrd_ctrl
  import sitrd_pkg::*;
(
  input  wire logic    clk_i,
  input  wire logic    rst_ni,
  input  wire logic    in_valid_i,
  output logic         in_ready_o,
  input  wire status_t status_i,
  output cmd_t         cmd_o
);

  state_e state_q, state_d;

  // State register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Next state and commands
  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = ST_CHECK;
        end
      end
      ST_CHECK: begin
        // drop the value when the alphabet is unusable
        state_d = status_i.alpha_ok ? ST_MUL : ST_IDLE;
      end
      ST_MUL: begin
        cmd_o.mul = 1'b1;
        state_d   = ST_FIX;
      end
      ST_FIX: begin
        cmd_o.fix = 1'b1;
        if (status_i.quo_zero) begin
          state_d = status_i.neg ? ST_SIGN : ST_EMIT;
        end else begin
          state_d = ST_MUL;
        end
      end
      ST_SIGN: begin
        if (status_i.out_free) begin
          cmd_o.emit_sign = 1'b1;
          state_d         = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (status_i.out_free) begin
          cmd_o.emit_digit = 1'b1;
          if (status_i.last_digit) begin
            state_d = ST_IDLE;
          end
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire

@@ rtl/sitrd_dp.sv @@
// Datapath of the radix digit converter: configuration registers, alphabet check,
// reciprocal divider, digit stack and output register. Depends on sitrd_pkg.
`default_nettype none

module sitrd_dp
  import sitrd_pkg::*;
#(
  parameter int unsigned MAX_RADIX = MAX_RADIX_DEF
) (
  input  wire logic                      clk_i,
  input  wire logic                      rst_ni,
  input  wire logic                      cfg_we_i,
  input  wire logic [CFG_IDX_W-1:0]      cfg_index_i,
  input  wire logic [CFG_DATA_W-1:0]     cfg_wdata_i,
  input  wire logic signed [VALUE_W-1:0] value_i,
  input  wire cmd_t                      cmd_i,
  output status_t                        status_o,
  output logic                           out_valid_o,
  input  wire logic                      out_ready_i,
  output logic [CHAR_W-1:0]              out_char_o,
  output logic                           out_last_o
);

  localparam int unsigned IDX_W = $clog2(MAX_RADIX);

  logic [CHAR_W-1:0]    alpha_q [MAX_RADIX];
  logic [LEN_W-1:0]     len_q;
  logic                 alpha_ok;

  logic [VALUE_W-1:0]   mag_q;
  logic                 neg_q;
  logic [2*VALUE_W-1:0] prod_q;
  logic [VALUE_W-1:0]   q_est;
  logic [2*REM_W-1:0]   qd_full;
  logic [REM_W-1:0]     r_raw;
  logic                 r_over;
  logic [VALUE_W-1:0]   quo;
  logic [REM_W-1:0]     r_fix;
  logic [IDX_W-1:0]     digit;

  logic [IDX_W-1:0]     dig_q [DIGIT_DEPTH];
  logic [CNT_W-1:0]     cnt_q;
  logic [CNT_W-1:0]     top_cnt;
  logic [IDX_W-1:0]     top_digit;

  logic                 out_valid_q;
  logic [CHAR_W-1:0]    out_char_q;
  logic                 out_last_q;

  // Configuration registers; only the alphabet bytes that a radix can use are kept
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < MAX_RADIX; i++) begin
        alpha_q[i] <= '0;
      end
      len_q <= '0;
    end else if (cfg_we_i) begin
      for (int i = 0; i < MAX_RADIX; i++) begin
        if (cfg_index_i == ((i < BYTES_PER_WORD) ? CFG_ALPHA_LOW : CFG_ALPHA_HIGH)) begin
          alpha_q[i] <= cfg_wdata_i[(i % BYTES_PER_WORD)*CHAR_W +: CHAR_W];
        end
      end
      if (cfg_index_i == CFG_RADIX_LEN) begin
        len_q <= cfg_wdata_i[LEN_W-1:0];
      end
    end
  end

  // Alphabet check: length in range, printable, no sign characters, no repeats
  always_comb begin
    alpha_ok = (len_q >= MIN_RADIX) && (32'(len_q) <= MAX_RADIX);
    for (int i = 0; i < MAX_RADIX; i++) begin
      if (LEN_W'(i) < len_q) begin
        if (alpha_q[i] < CHAR_LOW || alpha_q[i] > CHAR_HIGH ||
            alpha_q[i] == PLUS_CHAR || alpha_q[i] == MINUS_CHAR) begin
          alpha_ok = 1'b0;
        end
        for (int j = i + 1; j < MAX_RADIX; j++) begin
          if (LEN_W'(j) < len_q && alpha_q[j] == alpha_q[i]) begin
            alpha_ok = 1'b0;
          end
        end
      end
    end
  end

  // Quotient estimate from the registered product, then one correction step.
  // The remainder stays below twice the radix, so its low bits suffice.
  assign q_est   = prod_q[2*VALUE_W-1:VALUE_W];
  assign qd_full = q_est[REM_W-1:0] * {1'b0, len_q};
  assign r_raw   = mag_q[REM_W-1:0] - qd_full[REM_W-1:0];
  assign r_over  = (r_raw >= {1'b0, len_q});
  assign quo     = q_est + VALUE_W'(r_over);
  assign r_fix   = r_over ? (r_raw - {1'b0, len_q}) : r_raw;
  assign digit   = r_fix[IDX_W-1:0];

  // Magnitude, sign and product registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      mag_q <= value_i[VALUE_W-1] ? (~$unsigned(value_i) + VALUE_W'(1)) : $unsigned(value_i);
      neg_q <= value_i[VALUE_W-1];
    end else if (cmd_i.fix) begin
      mag_q <= quo;
    end
    if (cmd_i.mul) begin
      prod_q <= mag_q * recip_f(len_q);
    end
  end

  // Digit stack: least significant pushed first, popped most significant first
  always_ff @(posedge clk_i) begin
    if (cmd_i.fix) begin
      dig_q[cnt_q[PTR_W-1:0]] <= digit;
    end
  end

  assign top_cnt   = cnt_q - CNT_W'(1);
  assign top_digit = dig_q[top_cnt[PTR_W-1:0]];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else if (cmd_i.load) begin
      cnt_q <= '0;
    end else if (cmd_i.fix) begin
      cnt_q <= cnt_q + CNT_W'(1);
    end else if (cmd_i.emit_digit) begin
      cnt_q <= top_cnt;
    end
  end

  // Output register: load a character, or clear once the sink takes it
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.emit_sign || cmd_i.emit_digit) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.emit_sign) begin
      out_char_q <= MINUS_CHAR;
      out_last_q <= 1'b0;
    end else if (cmd_i.emit_digit) begin
      out_char_q <= alpha_q[top_digit];
      out_last_q <= (cnt_q == CNT_W'(1));
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_char_o  = out_char_q;
  assign out_last_o  = out_last_q;

  assign status_o.alpha_ok   = alpha_ok;
  assign status_o.neg        = neg_q;
  assign status_o.quo_zero   = (quo == '0);
  assign status_o.last_digit = (cnt_q == CNT_W'(1));
  assign status_o.out_free   = !out_valid_q || out_ready_i;

  // The corrected remainder is a digit of the radix
  a_digit_in_radix: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.fix |-> (LEN_W'(r_fix) < len_q))
    else $error("remainder not below the radix after correction");

  // The stack never overflows on a push
  a_stack_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.fix |-> (cnt_q != CNT_W'(DIGIT_DEPTH)))
    else $error("digit stack overflow");

  // A digit is popped only from a non-empty stack into a free output register
  a_pop_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.emit_digit |-> (cnt_q != '0) && (!out_valid_q || out_ready_i))
    else $error("digit popped from empty stack or onto a held character");

endmodule

`default_nettype wire

@@ verif/radix_text_checker.sv @@
// Checker for the signed integer to radix text converter: follows the register
// writes, predicts the characters of every accepted value and compares them.
// Depends on sitrd_pkg and the channel interfaces in sitrd_if.
`timescale 1ns / 1ps

module radix_text_checker
  import sitrd_pkg::*;
#(
  parameter int unsigned MAX_RADIX = MAX_RADIX_DEF
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_wdata_i,
  sitrd_in_if                   in_ch,
  sitrd_out_if                  out_ch,
  output int                    outstanding_o,
  output int                    fail_count_o
);

  typedef struct packed {
    logic [CHAR_W-1:0] ch;
    logic              last;
  } text_char_t;

  logic [CFG_DATA_W-1:0] alpha_low;
  logic [CFG_DATA_W-1:0] alpha_high;
  logic [LEN_W-1:0]      radix_len;
  text_char_t            due_chars[$];

  // Append the characters of one value, or nothing for an unusable alphabet
  function automatic void spell_value(input logic [VALUE_W-1:0] v);
    logic [2*CFG_DATA_W-1:0] alph;
    logic [CHAR_W-1:0]       c;
    logic [CHAR_W-1:0]       digits[DIGIT_DEPTH];
    logic [VALUE_W:0]        mag;
    int                      len;
    int                      nd;
    int                      idx;
    bit                      ok;
    alph = {alpha_high, alpha_low};
    len  = int'(radix_len);
    ok   = (len >= MIN_RADIX) && (len <= MAX_RADIX) && (len <= 16);
    for (int i = 0; i < 16; i++) begin
      if (ok && i < len) begin
        c = alph[i*CHAR_W +: CHAR_W];
        if (c < CHAR_LOW || c > CHAR_HIGH || c == PLUS_CHAR || c == MINUS_CHAR) ok = 1'b0;
        for (int j = i + 1; j < 16; j++) begin
          if (j < len && alph[j*CHAR_W +: CHAR_W] == c) ok = 1'b0;
        end
      end
    end
    if (!ok) return;
    // Widen by one bit so the most negative value has an exact magnitude
    mag = v[VALUE_W-1] ? ((VALUE_W+1)'(0) - {v[VALUE_W-1], v}) : {1'b0, v};
    nd  = 0;
    do begin
      idx        = int'(mag % (VALUE_W+1)'(len));
      digits[nd] = alph[idx*CHAR_W +: CHAR_W];
      mag        = mag / (VALUE_W+1)'(len);
      nd++;
    end while (mag != 0 && nd < DIGIT_DEPTH);
    if (v[VALUE_W-1]) due_chars.push_back('{MINUS_CHAR, 1'b0});
    for (int k = nd - 1; k >= 0; k--) due_chars.push_back('{digits[k], k == 0});
  endfunction

  // Track registers, predict on input transfers, compare on output transfers
  always @(posedge clk_i or negedge rst_ni) begin
    text_char_t want;
    if (!rst_ni) begin
      alpha_low  <= '0;
      alpha_high <= '0;
      radix_len  <= '0;
      due_chars.delete();
      fail_count_o  = 0;
      outstanding_o <= 0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_index_i)
          CFG_ALPHA_LOW:  alpha_low  <= cfg_wdata_i;
          CFG_ALPHA_HIGH: alpha_high <= cfg_wdata_i;
          CFG_RADIX_LEN:  radix_len  <= cfg_wdata_i[LEN_W-1:0];
          default: ;
        endcase
      end
      if (in_ch.valid && in_ch.ready) spell_value(in_ch.value);
      if (out_ch.valid && out_ch.ready) begin
        if (due_chars.size() == 0) begin
          $error("out_char %h last_char %b with no character pending",
                 out_ch.out_char, out_ch.last_char);
          fail_count_o++;
        end else begin
          want = due_chars.pop_front();
          if (out_ch.out_char !== want.ch) begin
            $error("out_char: expected %h, actual %h", want.ch, out_ch.out_char);
            fail_count_o++;
          end
          if (out_ch.last_char !== want.last) begin
            $error("last_char: expected %b, actual %b", want.last, out_ch.last_char);
            fail_count_o++;
          end
        end
      end
      outstanding_o <= due_chars.size();
    end
  end

endmodule

@@ verif/tb_signed_integer_to_radix_digits.sv @@
// Testbench top of the radix text converter: clock, reset, register writes,
// value stimulus and output back-pressure; the verdict comes from the checker.
// Depends on sitrd_pkg, sitrd_if, the block and radix_text_checker.
`timescale 1ns / 1ps

module tb_signed_integer_to_radix_digits;
  import sitrd_pkg::*;

  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_IDX = 2'd3;
  localparam int DRAIN_CYCLES   = 110;
  localparam int SQUEEZE_CYCLES = 300;
  localparam int VALID_ITEMS    = 350;

  typedef enum int {
    FLT_NONE,
    FLT_LEN_ZERO,
    FLT_LEN_ONE,
    FLT_LEN_OVER,
    FLT_LEN_MAX,
    FLT_DUP,
    FLT_LOW_CHAR,
    FLT_HIGH_CHAR,
    FLT_PLUS,
    FLT_MINUS,
    FLT_ALL_ONES
  } alpha_fault_e;

  logic                  clk;
  logic                  rst_n;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_wdata;
  int                    outstanding;
  int                    fail_count;
  bit                    squeeze_req;
  bit                    rx_quiet;

  sitrd_in_if  in_ch ();
  sitrd_out_if out_ch ();

  signed_integer_to_radix_digits #(
    .MAX_RADIX(MAX_RADIX_DEF)
  ) u_top (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .cfg_we_i   (cfg_we),
    .cfg_index_i(cfg_index),
    .cfg_wdata_i(cfg_wdata),
    .in_i       (in_ch),
    .out_o      (out_ch)
  );

  radix_text_checker #(
    .MAX_RADIX(MAX_RADIX_DEF)
  ) u_checker (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .cfg_we_i     (cfg_we),
    .cfg_index_i  (cfg_index),
    .cfg_wdata_i  (cfg_wdata),
    .in_ch        (in_ch),
    .out_ch       (out_ch),
    .outstanding_o(outstanding),
    .fail_count_o (fail_count)
  );

  always begin
    clk = 1'b0;
    #6;
    clk = 1'b1;
    #6;
  end

  // Hard stop in case the block hangs
  initial begin
    #15_000_000;
    $display("tb: failure");
    $finish;
  end

  // Idle length: mostly none or short, now and then long
  function automatic int gap_len(input bit quiet);
    int roll;
    roll = $urandom_range(0, 99);
    if (quiet || roll < 55) return 0;
    if (roll < 88) return $urandom_range(1, 3);
    if (roll < 97) return $urandom_range(4, 10);
    return $urandom_range(11, 20);
  endfunction

  function automatic logic [127:0] alphabet_from(input string s);
    logic [127:0] a;
    a = '0;
    for (int i = 0; i < s.len() && i < 16; i++) a[i*CHAR_W +: CHAR_W] = s[i];
    return a;
  endfunction

  // Sixteen distinct printable characters, none of them a sign
  function automatic logic [127:0] random_alphabet();
    logic [127:0]      a;
    bit [255:0]        taken;
    logic [CHAR_W-1:0] c;
    taken = '0;
    for (int i = 0; i < 16; i++) begin
      do c = CHAR_W'($urandom_range(CHAR_LOW, CHAR_HIGH));
      while (taken[c] || c == PLUS_CHAR || c == MINUS_CHAR);
      taken[c] = 1'b1;
      a[i*CHAR_W +: CHAR_W] = c;
    end
    return a;
  endfunction

  // Break a valid alphabet in one specific way
  function automatic void apply_fault(input alpha_fault_e f, inout logic [127:0] alph,
                                      inout logic [LEN_W-1:0] len);
    int i;
    int j;
    i = $urandom_range(0, len - 1);
    case (f)
      FLT_LEN_ZERO:  len = '0;
      FLT_LEN_ONE:   len = LEN_W'(1);
      FLT_LEN_OVER:  len = LEN_W'($urandom_range(MAX_RADIX_DEF + 1, 30));
      FLT_LEN_MAX:   len = '1;
      FLT_DUP: begin
        i = $urandom_range(1, len - 1);
        j = $urandom_range(0, i - 1);
        alph[i*CHAR_W +: CHAR_W] = alph[j*CHAR_W +: CHAR_W];
      end
      FLT_LOW_CHAR:  alph[i*CHAR_W +: CHAR_W] = $urandom_range(0, 1) ?
                       CHAR_LOW - 8'd1 : CHAR_W'($urandom_range(0, CHAR_LOW - 1));
      FLT_HIGH_CHAR: alph[i*CHAR_W +: CHAR_W] = $urandom_range(0, 1) ?
                       CHAR_HIGH + 8'd1 : CHAR_W'($urandom_range(CHAR_HIGH + 1, 255));
      FLT_PLUS:      alph[i*CHAR_W +: CHAR_W] = PLUS_CHAR;
      FLT_MINUS:     alph[i*CHAR_W +: CHAR_W] = MINUS_CHAR;
      FLT_ALL_ONES:  alph = '1;
      default: ;
    endcase
  endfunction

  // Mix of full-range, small, extreme and near-power-of-radix values
  function automatic logic [VALUE_W-1:0] rand_value(input int radix);
    int                 roll;
    int                 k;
    longint             p;
    logic [VALUE_W-1:0] v;
    roll = $urandom_range(0, 9);
    case (roll)
      0, 1, 2, 3: return $urandom;
      4, 5:       return VALUE_W'($urandom_range(0, 100)) - VALUE_W'(50);
      6: begin
        case ($urandom_range(0, 4))
          0:       return 32'h8000_0000;
          1:       return 32'h7FFF_FFFF;
          2:       return '0;
          3:       return '1;
          default: return 32'd1;
        endcase
      end
      7: begin
        p = 1;
        k = $urandom_range(1, 31);
        repeat (k) if (p * radix <= 64'h8000_0000) p = p * radix;
        p = p + $urandom_range(0, 2) - 1;
        v = p[VALUE_W-1:0];
        return $urandom_range(0, 1) ? -v : v;
      end
      default: begin
        v = $urandom >> $urandom_range(0, 31);
        return $urandom_range(0, 1) ? -v : v;
      end
    endcase
  endfunction

  // Wait for the block to drain, then for its worst-case latency
  task automatic settle();
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // Back-to-back register writes; the enable drops after the last one
  task automatic set_alphabet(input logic [127:0] alph, input logic [CFG_DATA_W-1:0] len_word,
                              input bit poke_spare);
    cfg_we    <= 1'b1;
    cfg_index <= CFG_ALPHA_LOW;
    cfg_wdata <= alph[63:0];
    @(posedge clk);
    cfg_index <= CFG_ALPHA_HIGH;
    cfg_wdata <= alph[127:64];
    @(posedge clk);
    cfg_index <= CFG_RADIX_LEN;
    cfg_wdata <= len_word;
    @(posedge clk);
    if (poke_spare) begin
      cfg_index <= CFG_SPARE_IDX;
      cfg_wdata <= '1;
      @(posedge clk);
    end
    cfg_we <= 1'b0;
  endtask

  // Offer one value after a random gap and hold it until the transfer
  task automatic send_value(input logic [VALUE_W-1:0] v, input bit quiet);
    int gap;
    gap = gap_len(quiet);
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.value <= v;
    do @(posedge clk); while (!in_ch.ready);
  endtask

  // Output back-pressure, with one long hold-off on request
  initial begin
    int hold;
    out_ch.ready <= 1'b0;
    @(posedge clk);
    forever begin
      if (squeeze_req) begin
        squeeze_req = 1'b0;
        hold = SQUEEZE_CYCLES;
      end else begin
        hold = gap_len(rx_quiet);
      end
      if (hold > 0) begin
        out_ch.ready <= 1'b0;
        repeat (hold) @(posedge clk);
      end
      out_ch.ready <= 1'b1;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
  end

  // Stimulus
  initial begin
    logic [127:0]          alph;
    logic [LEN_W-1:0]      len;
    logic [CFG_DATA_W-1:0] len_word;
    alpha_fault_e          fault;
    int                    n_items;
    int                    valid_sent;
    int                    phase;
    bit                    tx_quiet;

    rst_n       <= 1'b0;
    cfg_we      <= 1'b0;
    cfg_index   <= CFG_ALPHA_LOW;
    cfg_wdata   <= '0;
    in_ch.valid <= 1'b0;
    in_ch.value <= '0;
    squeeze_req = 1'b0;
    rx_quiet    = 1'b0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    // Reset alphabet is empty: the value gives no characters
    settle();
    send_value($urandom, 1'b0);
    in_ch.valid <= 1'b0;

    // Decimal digits, with a write to the unused register index
    settle();
    set_alphabet(alphabet_from("0123456789"), 64'd10, 1'b1);
    send_value(32'd0, 1'b0);
    send_value(32'd1, 1'b0);
    send_value('1, 1'b0);
    send_value(32'd9, 1'b0);
    send_value(32'd10, 1'b0);
    send_value(-32'sd10, 1'b0);
    send_value(32'h7FFF_FFFF, 1'b0);
    send_value(32'h8000_0000, 1'b0);
    in_ch.valid <= 1'b0;

    // Binary: the longest output; the unused upper alphabet is all ones
    settle();
    alph          = alphabet_from("01");
    alph[127:64]  = '1;
    alph[63:16]   = 48'({$urandom, $urandom});
    set_alphabet(alph, 64'd2, 1'b0);
    send_value(32'h8000_0000, 1'b0);
    send_value(32'h7FFF_FFFF, 1'b0);
    send_value(32'd0, 1'b0);
    send_value('1, 1'b0);
    in_ch.valid <= 1'b0;

    // Full radix with the boundary characters and junk above the length bits
    settle();
    set_alphabet(alphabet_from("!~*,./:;<=>?@AZa"), 64'hFFFF_FFFF_FFFF_FFF0, 1'b0);
    send_value(32'h8000_0000, 1'b0);
    send_value(32'h7FFF_FFFF, 1'b0);
    send_value(32'd16, 1'b0);
    send_value(-32'sd255, 1'b0);
    in_ch.valid <= 1'b0;

    // Each way an alphabet can be rejected
    for (int f = FLT_LEN_ZERO; f <= FLT_ALL_ONES; f++) begin
      alph = random_alphabet();
      len  = LEN_W'($urandom_range(MIN_RADIX, MAX_RADIX_DEF));
      apply_fault(alpha_fault_e'(f), alph, len);
      settle();
      set_alphabet(alph, CFG_DATA_W'(len), 1'b0);
      send_value($urandom, 1'b0);
      in_ch.valid <= 1'b0;
    end

    // Random phases, each with its own alphabet
    valid_sent = 0;
    phase      = 0;
    while (valid_sent < VALID_ITEMS) begin
      case ($urandom_range(0, 4))
        0:       len = MIN_RADIX;
        1:       len = LEN_W'(MAX_RADIX_DEF);
        default: len = LEN_W'($urandom_range(MIN_RADIX + 1, MAX_RADIX_DEF - 1));
      endcase
      alph = random_alphabet();
      if ($urandom_range(0, 1)) begin
        for (int i = 0; i < 16; i++) begin
          if (i >= len) alph[i*CHAR_W +: CHAR_W] = CHAR_W'($urandom);
        end
      end
      fault = ($urandom_range(0, 99) < 85 || phase == 2) ?
              FLT_NONE : alpha_fault_e'($urandom_range(FLT_LEN_ZERO, FLT_ALL_ONES));
      apply_fault(fault, alph, len);
      len_word = '0;
      if ($urandom_range(0, 3) == 0) len_word = {$urandom, $urandom};
      len_word[LEN_W-1:0] = len;
      n_items  = (fault == FLT_NONE) ? $urandom_range(10, 30) : 3;
      tx_quiet = ($urandom_range(0, 3) == 0);
      settle();
      set_alphabet(alph, len_word, 1'b0);
      rx_quiet = ($urandom_range(0, 3) == 0);
      // Stall the output for a long stretch while values keep coming
      if (phase == 2) begin
        squeeze_req = 1'b1;
        tx_quiet    = 1'b1;
        n_items     = 40;
      end
      repeat (n_items) begin
        send_value(rand_value(int'(len)), tx_quiet);
        if (fault == FLT_NONE) valid_sent++;
      end
      in_ch.valid <= 1'b0;
      phase++;
    end

    settle();
    if (fail_count == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
